>>> src/fifo_queue_with_remove_by_id_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the process wait queue
// Shared property forms used by the top level checks.
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_REMOVE_BY_ID_UNIT_DEFINES_SVH
`define FIFO_QUEUE_WITH_REMOVE_BY_ID_UNIT_DEFINES_SVH

// same-cycle implication
`define FQRID_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FQRID_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/fqrid_pkg.sv
// ----------------------------------------------------------------------------
// fqrid_pkg
// Types and codes used by the wait queue controller and datapath.
// ----------------------------------------------------------------------------
package fqrid_pkg;

	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_POP    = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_NOP    = 2'd3
	} q_cmd_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_FULL      = 2'd3
	} q_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} fsm_state_t;

	typedef struct packed {
		logic latch;
		logic scan;
		logic finish;
	} ctl_t;

	typedef struct packed {
		logic empty;
		logic scan_end;
	} dp_stat_t;

endpackage

>>> src/fqrid_ctrl.sv
// ----------------------------------------------------------------------------
// fqrid_ctrl
// Wait queue sequencer: takes a request, scans if pop/remove and not empty, finishes.
// ----------------------------------------------------------------------------
module fqrid_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  fqrid_pkg::q_cmd_t cmd,
	input  fqrid_pkg::dp_stat_t st,
	output fqrid_pkg::ctl_t   ctl,
	output logic              busy
);
	import fqrid_pkg::*;

	fsm_state_t state_q;
	fsm_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if ((cmd == CMD_POP || cmd == CMD_REMOVE) && !st.empty) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_SCAN: begin
				if (st.scan_end) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl.latch  = 1'b0;
		ctl.scan   = 1'b0;
		ctl.finish = 1'b0;
		busy       = 1'b1;
		case (state_q)
			S_IDLE: begin
				ctl.latch = start;
				busy      = 1'b0;
			end
			S_SCAN: begin
				ctl.scan = 1'b1;
			end
			S_FINISH: begin
				ctl.finish = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

>>> src/fqrid_dp.sv
// ----------------------------------------------------------------------------
// fqrid_dp
// Entry store, scan pipeline, gap closing and result registers.
// ----------------------------------------------------------------------------
module fqrid_dp #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_WIDTH    = 8,
	parameter int CW          = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fqrid_pkg::ctl_t     ctl,
	input  fqrid_pkg::q_cmd_t   cmd,
	input  logic [ID_WIDTH-1:0] proc_id,
	output fqrid_pkg::dp_stat_t st,
	output logic                done,
	output fqrid_pkg::q_status_t status,
	output logic [ID_WIDTH-1:0] popped_id,
	output logic [CW-1:0]       entry_count
);
	import fqrid_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	logic [ID_WIDTH-1:0] mem [QUEUE_DEPTH];

	q_cmd_t              cmd_q;
	logic [ID_WIDTH-1:0] id_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       rp_q;
	logic                rv_s1;
	logic [AW-1:0]       ra_s1;
	logic [ID_WIDTH-1:0] rd_s1;
	logic                found_q;
	logic [ID_WIDTH-1:0] hit_id_q;
	logic                done_q;
	q_status_t           res_status_q;
	logic [ID_WIDTH-1:0] res_popped_q;
	logic [CW-1:0]       res_count_q;

	logic                scan_end;
	logic                match;
	logic                full;
	logic                we;
	logic [AW-1:0]       wa;
	logic [ID_WIDTH-1:0] wd;
	q_status_t           fin_status;
	logic [CW-1:0]       fin_count;

	assign full     = (count_q == CW'(QUEUE_DEPTH));
	assign scan_end = (rp_q == count_q);
	assign match    = rv_s1 && !found_q && (cmd_q == CMD_POP || rd_s1 == id_q);

	assign st.empty    = (count_q == '0);
	assign st.scan_end = scan_end;

	// hold the request
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q <= cmd;
			id_q  <= proc_id;
		end
	end

	// advance the read pointer over the held entries; track the match, count and done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q     <= '0;
			rv_s1    <= 1'b0;
			found_q  <= 1'b0;
			count_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			rv_s1  <= ctl.scan && !scan_end;
			done_q <= ctl.finish;
			if (ctl.latch) begin
				rp_q    <= '0;
				found_q <= 1'b0;
			end else begin
				if (ctl.scan && !scan_end) begin
					rp_q <= rp_q + 1'b1;
				end
				if (match) begin
					found_q <= 1'b1;
				end
			end
			if (ctl.finish) begin
				count_q <= fin_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			hit_id_q <= '0;
		end else if (match && cmd_q == CMD_POP) begin
			hit_id_q <= rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.scan && !scan_end) begin
			rd_s1 <= mem[rp_q[AW-1:0]];
			ra_s1 <= rp_q[AW-1:0];
		end
	end

	// close the gap behind the match, or append at the tail
	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = '0;
		if (rv_s1 && found_q) begin
			we = 1'b1;
			wa = ra_s1 - 1'b1;
			wd = rd_s1;
		end else if (ctl.finish && cmd_q == CMD_APPEND && !full) begin
			we = 1'b1;
			wa = count_q[AW-1:0];
			wd = id_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_comb begin
		fin_status = STAT_OK;
		fin_count  = count_q;
		case (cmd_q)
			CMD_APPEND: begin
				if (full) begin
					fin_status = STAT_FULL;
				end else begin
					fin_count = count_q + 1'b1;
				end
			end
			CMD_POP, CMD_REMOVE: begin
				if (count_q == '0) begin
					fin_status = STAT_EMPTY;
				end else if (found_q) begin
					fin_count = count_q - 1'b1;
				end else begin
					fin_status = STAT_NOT_FOUND;
				end
			end
			default: begin
				fin_status = STAT_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			res_status_q <= fin_status;
			res_popped_q <= hit_id_q;
			res_count_q  <= fin_count;
		end
	end

	assign done        = done_q;
	assign status      = res_status_q;
	assign popped_id   = res_popped_q;
	assign entry_count = res_count_q;

endmodule

>>> src/fifo_queue_with_remove_by_id_unit.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_remove_by_id_unit
// Process wait queue with append, pop and remove by identifier.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low; cmd picks
// append, pop or remove, proc_id gives the identifier. Each request gives one
// result, shown for a single cycle with done high: status, popped_id and
// entry_count. The receiver cannot stall; results are never held back.
// Append, the unused command code, and any request on an empty queue skip the
// scan and go straight to the finish state. Pop and remove scan every held
// entry through the single read port of the entry store, one entry a cycle,
// and close the gap as they go; done is registered from the finish state
// that follows the scan. A new request is taken in the cycle that done is
// high. Reset empties the queue at once; no clearing pass is run.
// ----------------------------------------------------------------------------
`include "fifo_queue_with_remove_by_id_unit_defines.svh"

module fifo_queue_with_remove_by_id_unit #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_WIDTH    = 8,
	localparam int CW         = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          cmd,
	input  logic [ID_WIDTH-1:0] proc_id,
	output logic                done,
	output logic [1:0]          status,
	output logic [ID_WIDTH-1:0] popped_id,
	output logic [CW-1:0]       entry_count
);
	import fqrid_pkg::*;

	ctl_t      ctl;
	dp_stat_t  st;
	q_status_t res_status;
	q_cmd_t    cmd_e;

	assign cmd_e = q_cmd_t'(cmd);

	fqrid_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd_e),
		.st     (st),
		.ctl    (ctl),
		.busy   (busy)
	);

	fqrid_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_WIDTH    (ID_WIDTH),
		.CW          (CW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.cmd         (cmd_e),
		.proc_id     (proc_id),
		.st          (st),
		.done        (done),
		.status      (res_status),
		.popped_id   (popped_id),
		.entry_count (entry_count)
	);

	assign status = res_status;

	`FQRID_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after request")
	`FQRID_ASSERT_NOW(a_count_range, done, entry_count <= CW'(QUEUE_DEPTH), "count over depth")
	`FQRID_ASSERT_NOW(a_full_count, done && status == STAT_FULL, entry_count == CW'(QUEUE_DEPTH), "full with room left")
	`FQRID_ASSERT_NOW(a_popped_zero, done && status != STAT_OK, popped_id == '0, "popped id on failed request")

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: wait queue regression
// Drives append, pop, remove and unused-code requests through the start/busy
// handshake, predicts each result from a shadow copy of the queue, and compares
// every done strobe with the oldest predicted result.
// ----------------------------------------------------------------------------
import fqrid_pkg::*;

localparam int Q_DEPTH = 16;

typedef struct {
	logic [1:0] status;
	logic [7:0] popped;
	logic [4:0] count;
} queue_outcome_t;

class wait_queue_scoreboard;
	logic [7:0]     held_ids[$];
	queue_outcome_t pending[$];
	int             mismatches;
	int             checked;
	int             n_full;
	int             n_empty;
	int             n_missing;

	function void note_request(q_cmd_t c, logic [7:0] id);
		queue_outcome_t r;
		bit hit;
		r.status = STAT_OK;
		r.popped = '0;
		hit = 1'b0;
		case (c)
			CMD_APPEND: begin
				if (held_ids.size() >= Q_DEPTH)
					r.status = STAT_FULL;
				else
					held_ids.push_back(id);
			end
			CMD_POP: begin
				if (held_ids.size() == 0)
					r.status = STAT_EMPTY;
				else
					r.popped = held_ids.pop_front();
			end
			CMD_REMOVE: begin
				if (held_ids.size() == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					for (int k = 0; k < held_ids.size(); k++) begin
						if (held_ids[k] == id) begin
							held_ids.delete(k);
							hit = 1'b1;
							break;
						end
					end
					if (!hit)
						r.status = STAT_NOT_FOUND;
				end
			end
			default: ;
		endcase
		r.count = 5'(held_ids.size());
		pending.push_back(r);
	endfunction

	function void check_result(logic [1:0] st, logic [7:0] pop, logic [4:0] cnt);
		queue_outcome_t e;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: status %0d popped %02h count %0d",
					st, pop, cnt);
			return;
		end
		e = pending.pop_front();
		checked++;
		case (e.status)
			STAT_FULL:      n_full++;
			STAT_EMPTY:     n_empty++;
			STAT_NOT_FOUND: n_missing++;
			default: ;
		endcase
		if (st !== e.status || pop !== e.popped || cnt !== e.count) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch at %0t: status %0d/%0d popped %02h/%02h count %0d/%0d (exp/act)",
					$realtime, e.status, st, e.popped, pop, e.count, cnt);
		end
	endfunction
endclass

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_COUNT = 1250;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [1:0] cmd;
	logic [7:0] proc_id;
	logic       done;
	logic [1:0] status;
	logic [7:0] popped_id;
	logic [4:0] entry_count;

	wait_queue_scoreboard sb;
	int cycles;
	int n_append;
	int n_pop;
	int n_remove;
	int n_nop;
	bit quiet;

	fifo_queue_with_remove_by_id_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.proc_id     (proc_id),
		.done        (done),
		.status      (status),
		.popped_id   (popped_id),
		.entry_count (entry_count)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("fifo_queue_with_remove_by_id_unit regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(status, popped_id, entry_count);
	end

	task automatic send_request(input q_cmd_t c, input logic [7:0] id);
		start   = 1'b1;
		cmd     = c;
		proc_id = id;
		do @(posedge clk); while (busy);
		sb.note_request(c, id);
		case (c)
			CMD_APPEND: n_append++;
			CMD_POP:    n_pop++;
			CMD_REMOVE: n_remove++;
			default:    n_nop++;
		endcase
		@(negedge clk);
	endtask

	task automatic hold_off(input int n);
		start = 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain_results();
		start = 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic maybe_idle();
		if (!quiet && $urandom_range(0, 4) == 0)
			hold_off($urandom_range(1, 8));
	endtask

	function automatic q_cmd_t pick_cmd(input int fill_pct);
		if ($urandom_range(0, 99) < 3)
			return CMD_NOP;
		if ($urandom_range(0, 99) < fill_pct)
			return CMD_APPEND;
		return $urandom_range(0, 1) ? CMD_POP : CMD_REMOVE;
	endfunction

	function automatic logic [7:0] pick_id(input q_cmd_t c);
		if (c == CMD_REMOVE && sb.held_ids.size() != 0 && $urandom_range(0, 9) < 7)
			return sb.held_ids[$urandom_range(0, sb.held_ids.size() - 1)];
		if ($urandom_range(0, 9) < 3)
			return 8'h40 + 8'($urandom_range(0, 3));
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin
		logic [7:0] fill_ids [16];
		int issued;
		int fill_pct;
		bit paused;
		q_cmd_t c;

		fill_ids = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h7F,
			8'h10, 8'hC3, 8'h3C, 8'h02, 8'hFE, 8'h55, 8'hAA, 8'hEE};
		sb      = new();
		arst_n  = 1'b0;
		start   = 1'b0;
		cmd     = CMD_NOP;
		proc_id = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_request(CMD_POP, 8'h00);
		send_request(CMD_REMOVE, 8'h00);
		send_request(CMD_NOP, 8'hFF);
		foreach (fill_ids[i]) begin
			send_request(CMD_APPEND, fill_ids[i]);
			maybe_idle();
		end
		send_request(CMD_APPEND, 8'h33);
		send_request(CMD_REMOVE, 8'h00);
		send_request(CMD_REMOVE, 8'hEE);
		send_request(CMD_REMOVE, 8'h5A);
		send_request(CMD_REMOVE, 8'h99);
		send_request(CMD_POP, 8'h00);

		issued   = 0;
		paused   = 1'b0;
		fill_pct = 50;
		while (issued < RANDOM_COUNT) begin
			if (issued % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: fill_pct = 75;
					1: fill_pct = 25;
					default: fill_pct = 50;
				endcase
				quiet = ($urandom_range(0, 3) == 0) || (issued >= RANDOM_COUNT - 150);
			end
			if (!paused && issued == RANDOM_COUNT / 2) begin
				drain_results();
				paused = 1'b1;
			end
			c = pick_cmd(fill_pct);
			send_request(c, pick_id(c));
			if (c != CMD_NOP)
				issued++;
			maybe_idle();
		end

		drain_results();
		repeat (Q_DEPTH + 8) @(posedge clk);

		$display("requests: %0d append, %0d pop, %0d remove, %0d unused code; %0d results checked",
			n_append, n_pop, n_remove, n_nop, sb.checked);
		$display("outcomes: %0d full, %0d empty, %0d not found, %0d mismatches",
			sb.n_full, sb.n_empty, sb.n_missing, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("fifo_queue_with_remove_by_id_unit regression: pass");
		else
			$display("fifo_queue_with_remove_by_id_unit regression: fail");
		$finish;
	end

endmodule
